### rtl/blcs_pkg.sv
`timescale 1ns / 1ps

package blcs_pkg;

  // Fixed field widths
  localparam int ADDR_W      = 9;
  localparam int STORE_DEPTH = 512;
  localparam int COLOR_W     = 8;
  localparam int PERIOD_W    = 23;
  localparam int MINP_W      = 16;
  localparam int FPT_W       = 12;
  localparam int REFRESH_W   = 13;
  localparam int LAYER_W     = 3;
  localparam int BIT_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Parameter defaults
  localparam int CUBE_SIZE_DEF = 8;
  localparam int BAM_BITS_DEF  = 8;

  localparam logic [MINP_W-1:0] MIN_PERIOD_RST = 16'd1;
  localparam logic [FPT_W-1:0]  FPT_RST        = 12'd0;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_SLOT  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PERIOD      = 2'd0,
    CFG_FRAMES_PER_TICK = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic store_wr;
    logic slot_begin;
    logic scan_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_last;
  } ctrl_sts_t;

endpackage

### rtl/blcs_ctrl.sv
`timescale 1ns / 1ps

module blcs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  op_i,
  output logic                  in_stall_o,
  input  blcs_pkg::ctrl_sts_t   sts_i,
  output blcs_pkg::ctrl_cmd_t   cmd_o
);

  blcs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blcs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      blcs_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = blcs_pkg::ST_IDLE;
        end
      end
      blcs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (blcs_pkg::op_e'(op_i) == blcs_pkg::OP_SLOT) begin
            cmd_o.slot_begin = 1'b1;
            state_d          = blcs_pkg::ST_SCAN;
          end else begin
            cmd_o.store_wr = 1'b1;
          end
        end
      end
      blcs_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        // drop back once the final voxel read is issued
        if (sts_i.issue_last) begin
          state_d = blcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/blcs_datapath.sv
`timescale 1ns / 1ps

module blcs_datapath #(
  parameter int CUBE_SIZE = blcs_pkg::CUBE_SIZE_DEF,
  parameter int BAM_BITS  = blcs_pkg::BAM_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blcs_pkg::ctrl_cmd_t                 cmd_i,
  output blcs_pkg::ctrl_sts_t                 sts_o,
  input  logic                                cfg_valid_i,
  input  logic [blcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [blcs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [blcs_pkg::ADDR_W-1:0]         voxel_index_i,
  input  logic [blcs_pkg::COLOR_W-1:0]        red_i,
  input  logic [blcs_pkg::COLOR_W-1:0]        green_i,
  input  logic [blcs_pkg::COLOR_W-1:0]        blue_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                red_bit_o,
  output logic                                green_bit_o,
  output logic                                blue_bit_o,
  output logic [blcs_pkg::LAYER_W-1:0]        active_layer_o,
  output logic [blcs_pkg::PERIOD_W-1:0]       next_period_o,
  output logic                                frame_tick_o,
  output logic                                last_o
);

  localparam int LayerVoxels = CUBE_SIZE * CUBE_SIZE;
  localparam int VoxW        = $clog2(LayerVoxels);
  localparam int ColorBits   = 3 * blcs_pkg::COLOR_W;

  // Configuration registers
  logic [blcs_pkg::MINP_W-1:0] min_period_q;
  logic [blcs_pkg::FPT_W-1:0]  fpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= blcs_pkg::MIN_PERIOD_RST;
      fpt_q        <= blcs_pkg::FPT_RST;
    end else if (cfg_valid_i) begin
      if (blcs_pkg::cfg_idx_e'(cfg_index_i) == blcs_pkg::CFG_MIN_PERIOD) begin
        min_period_q <= cfg_data_i;
      end else if (blcs_pkg::cfg_idx_e'(cfg_index_i) == blcs_pkg::CFG_FRAMES_PER_TICK) begin
        fpt_q <= cfg_data_i[blcs_pkg::FPT_W-1:0];
      end
    end
  end

  // Scan counters
  logic [blcs_pkg::BIT_W-1:0]     bit_q, bit_d;
  logic [blcs_pkg::LAYER_W-1:0]   layer_q, layer_d;
  logic [blcs_pkg::PERIOD_W-1:0]  period_q, period_d;
  logic [blcs_pkg::REFRESH_W-1:0] refresh_q, refresh_d;
  logic                           tick_q, tick_d;
  logic [blcs_pkg::BIT_W:0]       bit_inc;
  logic [blcs_pkg::LAYER_W:0]     layer_inc;
  logic [blcs_pkg::REFRESH_W-1:0] refresh_inc;

  always_comb begin
    bit_inc     = {1'b0, bit_q} + 1'b1;
    layer_inc   = {1'b0, layer_q} + 1'b1;
    refresh_inc = refresh_q + 1'b1;
    bit_d       = bit_q;
    layer_d     = layer_q;
    period_d    = period_q;
    refresh_d   = refresh_q;
    tick_d      = 1'b0;
    if (bit_inc >= (blcs_pkg::BIT_W + 1)'(BAM_BITS)) begin
      // past the top bit: reload the base period and step a layer
      bit_d    = '0;
      period_d = blcs_pkg::PERIOD_W'(min_period_q);
      if (layer_inc >= (blcs_pkg::LAYER_W + 1)'(CUBE_SIZE)) begin
        layer_d = '0;
        if (refresh_inc > blcs_pkg::REFRESH_W'(fpt_q)) begin
          tick_d    = 1'b1;
          refresh_d = '0;
        end else begin
          refresh_d = refresh_inc;
        end
      end else begin
        layer_d = layer_inc[blcs_pkg::LAYER_W-1:0];
      end
    end else begin
      bit_d    = bit_inc[blcs_pkg::BIT_W-1:0];
      period_d = {period_q[blcs_pkg::PERIOD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q     <= '0;
      layer_q   <= '0;
      period_q  <= blcs_pkg::PERIOD_W'(blcs_pkg::MIN_PERIOD_RST);
      refresh_q <= '0;
      tick_q    <= 1'b0;
    end else if (cmd_i.slot_begin) begin
      bit_q     <= bit_d;
      layer_q   <= layer_d;
      period_q  <= period_d;
      refresh_q <= refresh_d;
      tick_q    <= tick_d;
    end
  end

  // Clear sweep address
  logic [blcs_pkg::ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Read pipeline: issue -> memory data stage -> output register
  logic            out_free;
  logic            b_valid_q;
  logic            b_move;
  logic            b_free;
  logic            issue;
  logic            vox_last;
  logic [VoxW-1:0] vox_q;
  logic [blcs_pkg::ADDR_W-1:0] rd_addr;

  assign out_free = !out_valid_o || !out_stall_i;
  assign b_move   = b_valid_q && out_free;
  assign b_free   = !b_valid_q || b_move;
  assign issue    = cmd_i.scan_en && b_free;
  assign vox_last = (vox_q == VoxW'(LayerVoxels - 1));
  assign rd_addr  = blcs_pkg::ADDR_W'(layer_q * blcs_pkg::ADDR_W'(LayerVoxels))
                  + blcs_pkg::ADDR_W'(vox_q);

  assign sts_o.clr_last   = cmd_i.clr_en && (clr_q == blcs_pkg::ADDR_W'(blcs_pkg::STORE_DEPTH - 1));
  assign sts_o.issue_last = issue && vox_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vox_q <= '0;
    end else if (issue) begin
      vox_q <= vox_last ? '0 : vox_q + 1'b1;
    end
  end

  // Voxel store
  logic [ColorBits-1:0] store_mem [blcs_pkg::STORE_DEPTH];
  logic [ColorBits-1:0] b_rdata_q;
  logic                 wr_en;
  logic [blcs_pkg::ADDR_W-1:0] wr_addr;
  logic [ColorBits-1:0] wr_data;

  assign wr_en   = cmd_i.clr_en || cmd_i.store_wr;
  assign wr_addr = cmd_i.clr_en ? clr_q : voxel_index_i;
  assign wr_data = cmd_i.clr_en ? '0 : {red_i, green_i, blue_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_rdata_q <= store_mem[rd_addr];
    end
  end

  // Per-beat slot data, copied at issue so a following slot cannot disturb it
  logic [blcs_pkg::BIT_W-1:0]    b_bit_q;
  logic [blcs_pkg::LAYER_W-1:0]  b_layer_q;
  logic [blcs_pkg::PERIOD_W-1:0] b_period_q;
  logic                          b_tick_q;
  logic                          b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (issue) begin
      b_valid_q <= 1'b1;
    end else if (b_move) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_bit_q    <= bit_q;
      b_layer_q  <= layer_q;
      b_period_q <= period_q;
      b_tick_q   <= tick_q;
      b_last_q   <= vox_last;
    end
  end

  logic [blcs_pkg::COLOR_W-1:0] b_red, b_green, b_blue;

  assign b_red   = b_rdata_q[3*blcs_pkg::COLOR_W-1:2*blcs_pkg::COLOR_W];
  assign b_green = b_rdata_q[2*blcs_pkg::COLOR_W-1:blcs_pkg::COLOR_W];
  assign b_blue  = b_rdata_q[blcs_pkg::COLOR_W-1:0];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (b_move) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      red_bit_o      <= b_red[b_bit_q];
      green_bit_o    <= b_green[b_bit_q];
      blue_bit_o     <= b_blue[b_bit_q];
      active_layer_o <= b_layer_q;
      next_period_o  <= b_period_q;
      frame_tick_o   <= b_tick_q;
      last_o         <= b_last_q;
    end
  end

endmodule

### rtl/bam_led_cube_scanner_top.sv
`timescale 1ns / 1ps

// Write item: stored in the voxel store, no result beat.
// Slot item: its beats pass the read issue, the memory data stage and the output register,
// one beat a cycle while the output does not stall, CUBE_SIZE*CUBE_SIZE beats (64 by default);
// output stalls hold the scan, and the next item is taken once the last voxel read is issued.
// Throughput is set by the single read port of the voxel store, one voxel per cycle without stalls.
// Reset (async, active low) clears counters and config, then a pass over all 512 entries zeroes
// the voxel store while in_stall_o stays high; config writes are taken throughout.
module bam_led_cube_scanner_top #(
  parameter int CUBE_SIZE = blcs_pkg::CUBE_SIZE_DEF,
  parameter int BAM_BITS  = blcs_pkg::BAM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [blcs_pkg::ADDR_W-1:0]       voxel_index_i,
  input  logic [blcs_pkg::COLOR_W-1:0]      red_i,
  input  logic [blcs_pkg::COLOR_W-1:0]      green_i,
  input  logic [blcs_pkg::COLOR_W-1:0]      blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              red_bit_o,
  output logic                              green_bit_o,
  output logic                              blue_bit_o,
  output logic [blcs_pkg::LAYER_W-1:0]      active_layer_o,
  output logic [blcs_pkg::PERIOD_W-1:0]     next_period_o,
  output logic                              frame_tick_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [blcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [blcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  blcs_pkg::ctrl_cmd_t cmd;
  blcs_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  blcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blcs_datapath #(
    .CUBE_SIZE (CUBE_SIZE),
    .BAM_BITS  (BAM_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .voxel_index_i  (voxel_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_bit_o      (red_bit_o),
    .green_bit_o    (green_bit_o),
    .blue_bit_o     (blue_bit_o),
    .active_layer_o (active_layer_o),
    .next_period_o  (next_period_o),
    .frame_tick_o   (frame_tick_o),
    .last_o         (last_o)
  );

`ifndef NO_ASSERTIONS
  // a slot beat starts a scan, so the input side holds off next cycle
  a_slot_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == blcs_pkg::OP_SLOT) |=> in_stall_o)
    else $error("slot item did not start a scan");

  // within a slot the pipeline keeps the next beat ready behind the output register
  a_no_bubble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a slot's beats");

  a_layer_steady : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> $stable(active_layer_o))
    else $error("active layer changed inside a slot");
`endif

endmodule

### dv/bam_led_cube_scanner_top_tb.sv
`timescale 1ns / 1ps

module bam_led_cube_scanner_top_tb;

  localparam int CUBE         = blcs_pkg::CUBE_SIZE_DEF;
  localparam int BAM          = blcs_pkg::BAM_BITS_DEF;
  localparam int LAYER_VOX    = CUBE * CUBE;
  localparam int IDLE_PCT     = 36;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_CYCLES = 400000;

  // indexes past the two registers, expected to be ignored
  localparam logic [blcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [blcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                          red_bit;
    logic                          green_bit;
    logic                          blue_bit;
    logic [blcs_pkg::LAYER_W-1:0]  layer;
    logic [blcs_pkg::PERIOD_W-1:0] period;
    logic                          tick;
    logic                          last;
  } scan_beat_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            op_i;
  logic [blcs_pkg::ADDR_W-1:0]     voxel_index_i;
  logic [blcs_pkg::COLOR_W-1:0]    red_i;
  logic [blcs_pkg::COLOR_W-1:0]    green_i;
  logic [blcs_pkg::COLOR_W-1:0]    blue_i;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            red_bit_o;
  logic                            green_bit_o;
  logic                            blue_bit_o;
  logic [blcs_pkg::LAYER_W-1:0]    active_layer_o;
  logic [blcs_pkg::PERIOD_W-1:0]   next_period_o;
  logic                            frame_tick_o;
  logic                            last_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [blcs_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [blcs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  bam_led_cube_scanner_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .voxel_index_i  (voxel_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_bit_o      (red_bit_o),
    .green_bit_o    (green_bit_o),
    .blue_bit_o     (blue_bit_o),
    .active_layer_o (active_layer_o),
    .next_period_o  (next_period_o),
    .frame_tick_o   (frame_tick_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // scanner mirror: colors, BAM position, layer, period, refresh count, registers
  logic [3*blcs_pkg::COLOR_W-1:0] voxel_color_mirror [blcs_pkg::STORE_DEPTH];
  int unsigned                    bam_pos;
  int unsigned                    scan_layer;
  logic [blcs_pkg::PERIOD_W-1:0]  slot_len;
  logic [blcs_pkg::REFRESH_W-1:0] wrap_count;
  logic [blcs_pkg::MINP_W-1:0]    minp_reg;
  logic [blcs_pkg::FPT_W-1:0]     fpt_reg;

  scan_beat_t pending_voxel_beats [$];

  int  mismatch_count;
  int  beats_checked;
  int  ticks_seen;
  int  slot_items;
  int  write_items;
  int  cycle_count;
  int  hold_req;
  int  hold_seen;
  int  hold_left;
  bit  calm_phase;

  function automatic string beat_str(input scan_beat_t b);
    return $sformatf("rgb %0b%0b%0b layer %0d period %0d tick %0b last %0b",
                     b.red_bit, b.green_bit, b.blue_bit, b.layer, b.period, b.tick, b.last);
  endfunction

  function automatic logic [blcs_pkg::COLOR_W-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return blcs_pkg::COLOR_W'($urandom_range(255));
  endfunction

  // advance the BAM slot and queue one beat per voxel of the active layer
  task automatic compute_slot_beats();
    scan_beat_t                     beat;
    logic                           tick;
    logic [3*blcs_pkg::COLOR_W-1:0] color;
    int unsigned                    base;
    tick = 1'b0;
    bam_pos++;
    if (bam_pos >= BAM) begin
      slot_len = blcs_pkg::PERIOD_W'(minp_reg);
      scan_layer++;
      if (scan_layer >= CUBE) begin
        wrap_count = wrap_count + 1'b1;
        if (wrap_count > blcs_pkg::REFRESH_W'(fpt_reg)) begin
          tick       = 1'b1;
          wrap_count = '0;
        end
        scan_layer = 0;
      end
      bam_pos = 0;
    end else begin
      slot_len = slot_len << 1;
    end
    base = LAYER_VOX * scan_layer;
    for (int i = 0; i < LAYER_VOX; i++) begin
      color          = voxel_color_mirror[(base + i) % blcs_pkg::STORE_DEPTH];
      beat.red_bit   = color[2*blcs_pkg::COLOR_W + bam_pos];
      beat.green_bit = color[blcs_pkg::COLOR_W + bam_pos];
      beat.blue_bit  = color[bam_pos];
      beat.layer     = blcs_pkg::LAYER_W'(scan_layer);
      beat.period    = slot_len;
      beat.tick      = tick;
      beat.last      = (i == LAYER_VOX - 1);
      pending_voxel_beats.push_back(beat);
    end
  endtask

  task automatic send_item(input blcs_pkg::op_e op, input logic [blcs_pkg::ADDR_W-1:0] idx,
                           input logic [blcs_pkg::COLOR_W-1:0] r,
                           input logic [blcs_pkg::COLOR_W-1:0] g,
                           input logic [blcs_pkg::COLOR_W-1:0] b);
    while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    voxel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (op == blcs_pkg::OP_WRITE) begin
      voxel_color_mirror[idx] = {r, g, b};
      write_items++;
    end else begin
      compute_slot_beats();
      slot_items++;
    end
  endtask

  task automatic cfg_write(input logic [blcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [blcs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      blcs_pkg::CFG_MIN_PERIOD:      minp_reg = data;
      blcs_pkg::CFG_FRAMES_PER_TICK: fpt_reg = data[blcs_pkg::FPT_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, let every queued beat arrive, then give trailing writes time to land
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_voxel_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_voxel_store_extremes();
    send_item(blcs_pkg::OP_WRITE, 9'd0,   8'hFF, 8'h00, 8'hAA);
    send_item(blcs_pkg::OP_WRITE, 9'd63,  8'h01, 8'h80, 8'hFF);
    send_item(blcs_pkg::OP_WRITE, 9'd64,  8'hFF, 8'hFF, 8'hFF);
    send_item(blcs_pkg::OP_WRITE, 9'd127, 8'h55, 8'hAA, 8'h00);
    send_item(blcs_pkg::OP_WRITE, 9'd511, 8'hFF, 8'hFF, 8'hFF);
    send_item(blcs_pkg::OP_WRITE, 9'd130, 8'h0F, 8'hF0, 8'h3C);
    repeat (3) send_item(blcs_pkg::OP_SLOT, 9'h1FF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // zero period written mid-cycle: doubling goes on from the old value until reload
  task automatic test_zero_min_period();
    wait_drained();
    cfg_write(CFG_SPARE_A, 16'hFFFF);
    cfg_write(CFG_SPARE_B, 16'hFFFF);
    cfg_write(blcs_pkg::CFG_MIN_PERIOD, 16'h0000);
    repeat (6) send_item(blcs_pkg::OP_SLOT, 9'h000, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_max_min_period();
    wait_drained();
    cfg_write(blcs_pkg::CFG_MIN_PERIOD, 16'hFFFF);
    cfg_write(blcs_pkg::CFG_FRAMES_PER_TICK, 16'hFFFF);
    repeat (7) send_item(blcs_pkg::OP_SLOT, 9'h0AA, 8'h5A, 8'hA5, 8'h3C);
  endtask

  // receiver holds off while slots keep coming, so the input side backs up
  task automatic test_output_backpressure();
    wait_drained();
    hold_req <= hold_req + 1;
    repeat (5) send_item(blcs_pkg::OP_SLOT, blcs_pkg::ADDR_W'($urandom_range(511)),
                         pick_level(), pick_level(), pick_level());
    send_item(blcs_pkg::OP_WRITE,
              blcs_pkg::ADDR_W'((scan_layer * LAYER_VOX) + $urandom_range(LAYER_VOX - 1)),
              pick_level(), pick_level(), pick_level());
  endtask

  task automatic test_random_scan(input int n_items, input logic [blcs_pkg::MINP_W-1:0] minp,
                                  input logic [blcs_pkg::FPT_W-1:0] fpt, input bit calm);
    logic [3:0]                  pad;
    logic [blcs_pkg::ADDR_W-1:0] idx;
    wait_drained();
    pad = 4'($urandom_range(15));
    cfg_write(blcs_pkg::CFG_MIN_PERIOD, minp);
    cfg_write(blcs_pkg::CFG_FRAMES_PER_TICK, {pad, fpt});
    calm_phase <= calm;
    repeat (n_items) begin
      if ($urandom_range(99) < 80) begin
        send_item(blcs_pkg::OP_SLOT, blcs_pkg::ADDR_W'($urandom_range(511)),
                  blcs_pkg::COLOR_W'($urandom_range(255)),
                  blcs_pkg::COLOR_W'($urandom_range(255)),
                  blcs_pkg::COLOR_W'($urandom_range(255)));
      end else begin
        // mostly hit the layer on screen now or next, so written colors get shown
        if ($urandom_range(99) < 60)
          idx = blcs_pkg::ADDR_W'(((scan_layer + $urandom_range(1)) % CUBE) * LAYER_VOX
                                  + $urandom_range(LAYER_VOX - 1));
        else
          idx = blcs_pkg::ADDR_W'($urandom_range(blcs_pkg::STORE_DEPTH - 1));
        send_item(blcs_pkg::OP_WRITE, idx, pick_level(), pick_level(), pick_level());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm_phase) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    scan_beat_t got;
    scan_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.red_bit   = red_bit_o;
      got.green_bit = green_bit_o;
      got.blue_bit  = blue_bit_o;
      got.layer     = active_layer_o;
      got.period    = next_period_o;
      got.tick      = frame_tick_o;
      got.last      = last_o;
      if (pending_voxel_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected beat: got %s", beat_str(got));
      end else begin
        want = pending_voxel_beats.pop_front();
        beats_checked++;
        if (want.tick && want.last) ticks_seen++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("beat %0d mismatch: exp %s, got %s", beats_checked, beat_str(want),
                     beat_str(got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_voxel_beats.size());
      $display("bam_led_cube_scanner_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = blcs_pkg::OP_WRITE;
    voxel_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = blcs_pkg::CFG_MIN_PERIOD;
    cfg_data_i    = '0;
    calm_phase    = 1'b0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    foreach (voxel_color_mirror[i]) voxel_color_mirror[i] = '0;
    bam_pos    = 0;
    scan_layer = 0;
    minp_reg   = blcs_pkg::MIN_PERIOD_RST;
    fpt_reg    = blcs_pkg::FPT_RST;
    slot_len   = blcs_pkg::PERIOD_W'(blcs_pkg::MIN_PERIOD_RST);
    wrap_count = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_voxel_store_extremes();
    test_zero_min_period();
    test_max_min_period();
    test_output_backpressure();
    test_random_scan(58, blcs_pkg::MINP_W'($urandom_range(1, 65535)), 12'd0, 1'b0);
    test_random_scan(58, 16'hFFFF, 12'd1, 1'b1);
    test_random_scan(58, 16'h0000, 12'hFFF, 1'b0);
    test_random_scan(58, 16'h0001, blcs_pkg::FPT_W'($urandom_range(3)), 1'b0);
    wait_drained();

    if (pending_voxel_beats.size() != 0) begin
      mismatch_count += pending_voxel_beats.size();
      $display("%0d expected beats never arrived", pending_voxel_beats.size());
    end
    $display("Scanned %0d slots and stored %0d voxel writes; %0d beats compared, %0d frame ticks.",
             slot_items, write_items, beats_checked, ticks_seen);
    $display("Periods from 0 to 65535, tick thresholds 0 to 4095, one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("bam_led_cube_scanner_top_tb OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("bam_led_cube_scanner_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/blcs_pkg.sv
rtl/blcs_ctrl.sv
rtl/blcs_datapath.sv
rtl/bam_led_cube_scanner_top.sv
dv/bam_led_cube_scanner_top_tb.sv
